>>> hw/rtl/tccc_pkg.sv
// Shared types and codes for the text console cursor control block.
package tccc_pkg;

    // Longest command run one character byte can cause
    localparam int RunMax = 5;

    // Render command codes
    localparam logic [2:0] CmdGlyph  = 3'd0;
    localparam logic [2:0] CmdErase  = 3'd1;
    localparam logic [2:0] CmdCursor = 3'd2;
    localparam logic [2:0] CmdScroll = 3'd3;
    localparam logic [2:0] CmdClear  = 3'd4;

    // Character codes that act
    localparam logic [7:0] ChBackspace  = 8'd8;
    localparam logic [7:0] ChTab        = 8'd9;
    localparam logic [7:0] ChNewline    = 8'd10;
    localparam logic [7:0] ChFormFeed   = 8'd12;
    localparam logic [7:0] ChReturn     = 8'd13;
    localparam logic [7:0] ChPrintFirst = 8'd32;
    localparam logic [7:0] ChPrintLast  = 8'd126;
    localparam logic [7:0] TabStop      = 8'd8;

    typedef logic [6:0] t_row;
    typedef logic [7:0] t_col;

    typedef struct packed {
        logic [2:0] command;
        t_row       row;
        t_col       col;
        logic [7:0] glyph;
        logic       last;
    } t_entry;

    // Commands of one cursor move and where the cursor ends up
    typedef struct packed {
        logic [1:0]       n;
        t_entry [2:0]     entry;
        t_row             row;
        t_col             col;
    } t_move;

    // Whole command run of one byte
    typedef struct packed {
        t_entry [RunMax-1:0] entry;
        logic [2:0]          count;
    } t_run;

endpackage

>>> hw/rtl/tccc_decode.sv
// Decodes one character byte against the cursor into its command run and next cursor.
module tccc_decode #(
    parameter int COLS = 160,
    parameter int ROWS = 90
) (
    input  logic [7:0]           i_char,
    input  tccc_pkg::t_row       i_row,
    input  tccc_pkg::t_col       i_col,
    output tccc_pkg::t_run       o_run,
    output tccc_pkg::t_row       o_next_row,
    output tccc_pkg::t_col       o_next_col
);

    localparam tccc_pkg::t_row RowsC   = 7'(ROWS);
    localparam tccc_pkg::t_row LastRow = 7'(ROWS - 1);
    localparam tccc_pkg::t_col ColsC   = 8'(COLS);
    localparam tccc_pkg::t_col TabEdge = 8'(COLS - 8);

    function automatic tccc_pkg::t_entry mk(input logic [2:0] cmd, input tccc_pkg::t_row r,
                                            input tccc_pkg::t_col c, input logic [7:0] g);
        tccc_pkg::t_entry e;
        e.command = cmd;
        e.row     = r;
        e.col     = c;
        e.glyph   = g;
        e.last    = 1'b0;
        return e;
    endfunction

    // Erase old cell, set target, draw new cell; scroll when target row is off screen
    function automatic tccc_pkg::t_move place(input tccc_pkg::t_row r0, input tccc_pkg::t_col c0,
                                              input tccc_pkg::t_row r, input tccc_pkg::t_col c);
        tccc_pkg::t_move m;
        tccc_pkg::t_col  nc;
        m  = '0;
        nc = (c0 >= ColsC) ? '0 : c;
        if (r0 < RowsC && c0 < ColsC) begin
            m.entry[m.n] = mk(tccc_pkg::CmdErase, r0, c0, 8'd0);
            m.n = m.n + 2'd1;
        end
        if (r < RowsC) begin
            if (nc < ColsC) begin
                m.entry[m.n] = mk(tccc_pkg::CmdCursor, r, nc, 8'd0);
                m.n = m.n + 2'd1;
            end
            m.row = r;
            m.col = nc;
        end else begin
            m.entry[m.n] = mk(tccc_pkg::CmdScroll, '0, '0, 8'd0);
            m.n = m.n + 2'd1;
            m.entry[m.n] = mk(tccc_pkg::CmdCursor, LastRow, '0, 8'd0);
            m.n = m.n + 2'd1;
            m.row = LastRow;
            m.col = '0;
        end
        return m;
    endfunction

    always_comb begin
        tccc_pkg::t_move w;
        tccc_pkg::t_move a;
        tccc_pkg::t_row  r;
        tccc_pkg::t_col  c;
        logic            printable;
        logic            acted;
        logic            clear;
        logic [2:0]      k;
        tccc_pkg::t_run  run;

        w         = '0;
        a         = '0;
        r         = i_row;
        c         = i_col;
        acted     = 1'b0;
        clear     = 1'b0;
        printable = (i_char >= tccc_pkg::ChPrintFirst) && (i_char <= tccc_pkg::ChPrintLast);

        // pending wrap from a glyph at the right edge
        if (c >= ColsC) begin
            w = place(r, c, r + 7'd1, '0);
            r = w.row;
            c = w.col;
        end

        if (printable) begin
            a     = place(r, c, r, c + 8'd1);
            acted = 1'b1;
        end else begin
            unique case (i_char)
                tccc_pkg::ChBackspace: begin
                    if (c != '0) begin
                        a     = place(r, c, r, c - 8'd1);
                        acted = 1'b1;
                    end
                end
                tccc_pkg::ChTab: begin
                    if (c < TabEdge) begin
                        a = place(r, c, r, c + (tccc_pkg::TabStop - {5'd0, c[2:0]}));
                    end else begin
                        a = place(r, c, r + 7'd1, '0);
                    end
                    acted = 1'b1;
                end
                tccc_pkg::ChNewline: begin
                    a     = place(r, c, r + 7'd1, '0);
                    acted = 1'b1;
                end
                tccc_pkg::ChFormFeed: begin
                    a     = place(r, c, 7'd1, '0);
                    acted = 1'b1;
                    clear = 1'b1;
                end
                tccc_pkg::ChReturn: begin
                    a     = place(r, c, r, '0);
                    acted = 1'b1;
                end
                default: ;
            endcase
        end

        // gather the run in order
        run = '0;
        k   = '0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < w.n) begin
                run.entry[k] = w.entry[i];
                k = k + 3'd1;
            end
        end
        if (clear) begin
            run.entry[k] = mk(tccc_pkg::CmdClear, '0, '0, 8'd0);
            k = k + 3'd1;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < a.n) begin
                run.entry[k] = a.entry[i];
                k = k + 3'd1;
            end
        end
        if (printable && c < ColsC) begin
            run.entry[k] = mk(tccc_pkg::CmdGlyph, r, c, i_char);
            k = k + 3'd1;
        end
        if (k != '0) begin
            run.entry[k - 3'd1].last = 1'b1;
        end
        run.count = k;

        o_run      = run;
        o_next_row = acted ? a.row : r;
        o_next_col = acted ? a.col : c;
    end

endmodule

>>> hw/rtl/tccc_run_buf.sv
// Command run buffer and output register: hands out one command word per cycle while the receiver does not stall.
module tccc_run_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tccc_pkg::t_run    i_run,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_stall,
    output tccc_pkg::t_entry  o_entry
);

    tccc_pkg::t_entry [tccc_pkg::RunMax-1:0] r_list;
    tccc_pkg::t_entry [tccc_pkg::RunMax-1:0] n_list;
    logic [2:0]        r_left;
    logic              r_out_vld;
    tccc_pkg::t_entry  r_out;
    logic              out_free;
    logic              pop;

    assign out_free   = !r_out_vld || !i_stall;
    assign pop        = out_free && (r_left != 3'd0);
    assign o_can_load = (r_left == 3'd0) || (r_left == 3'd1 && out_free);

    // shift the run down one entry
    always_comb begin
        n_list = '0;
        for (int i = 0; i < tccc_pkg::RunMax - 1; i++) begin
            n_list[i] = r_list[i + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_vld <= pop;
            end
            if (i_load) begin
                r_left <= i_run.count;
            end else if (pop) begin
                r_left <= r_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_list[0];
        end
        if (i_load) begin
            r_list <= i_run.entry;
        end else if (pop) begin
            r_list <= n_list;
        end
    end

    assign o_valid = r_out_vld;
    assign o_entry = r_out;

`ifndef NO_ASSERTIONS
    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= 3'(tccc_pkg::RunMax))
        else $error("run buffer holds more commands than a run can have");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_left == 3'd0 || (r_left == 3'd1 && out_free)))
        else $error("run loaded over commands not yet sent");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_list[0].last) |-> (r_left == 3'd1))
        else $error("last_of_run flag not on the final buffered command");
`endif

endmodule

>>> hw/rtl/text_console_cursor_control.sv
// Top level of the text console cursor control block.
// Takes one character byte per input word and keeps a text cursor (row from 1, column from 0).
// Each byte turns into a run of 0 to 5 render command words, sent one per cycle in order
// while the receiver does not stall. Command codes: draw glyph, erase cursor cell, draw
// cursor cell, scroll up, clear screen. last_of_run marks the final word of a byte's run;
// a byte that causes nothing (unknown code, backspace at column 0) yields no word. A byte
// is held in an input register, decoded against the cursor in one pass and dropped into a
// run buffer that feeds the output register. The next byte is taken while the previous run
// drains; the single output register, one word a cycle while the receiver does not stall,
// sets the byte rate. Each byte's commands pass input register, run buffer, output register.
module text_console_cursor_control #(
    parameter int COLS = 160,
    parameter int ROWS = 90
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_command,
    output logic [6:0] o_cell_row,
    output logic [7:0] o_cell_column,
    output logic [7:0] o_glyph_code,
    output logic       o_last_of_run
);

    // input word register
    logic                r_in_vld;
    logic [7:0]          r_in_char;
    // cursor position
    tccc_pkg::t_row      r_row;
    tccc_pkg::t_col      r_col;

    tccc_pkg::t_run      run;
    tccc_pkg::t_row      n_row;
    tccc_pkg::t_col      n_col;
    tccc_pkg::t_entry    out_entry;
    logic                can_load;
    logic                load;

    // Decode the held byte against the current cursor
    tccc_decode #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_decode (
        .i_char     (r_in_char),
        .i_row      (r_row),
        .i_col      (r_col),
        .o_run      (run),
        .o_next_row (n_row),
        .o_next_col (n_col)
    );

    // Move the run into the buffer once it has room; advance the cursor with it
    assign load    = r_in_vld && can_load;
    assign o_stall = r_in_vld && !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_row    <= 7'd1;
            r_col    <= 8'd0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (load) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // Hold the byte until decoded
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_char_code;
        end
    end

    tccc_run_buf u_run_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_run      (run),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_entry    (out_entry)
    );

    assign o_command     = out_entry.command;
    assign o_cell_row    = out_entry.row;
    assign o_cell_column = out_entry.col;
    assign o_glyph_code  = out_entry.glyph;
    assign o_last_of_run = out_entry.last;

`ifndef NO_ASSERTIONS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row >= 7'd1) && (r_row < 7'(ROWS)) && (r_col <= 8'(COLS)))
        else $error("cursor left the screen area");
`endif

endmodule

>>> sim/text_console_cursor_control_test.sv
// Self-checking testbench for the text console cursor control block.
module text_console_cursor_control_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 160;
    localparam int ROWS = 90;

    // Marker in the character feed: hold the sender until every command has come back
    localparam int DrainMark = -1;
    localparam int RandomChars = 280;
    localparam int HoldAt = 150;     // command words seen before the long receiver hold
    localparam int HoldLen = 400;
    localparam int IdleLimit = 3000;
    localparam int EndWait = 20;

    typedef enum logic [1:0] {
        StallNone,
        StallLight,
        StallHeavy,
        StallAlternate
    } t_stall_pattern;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_char_code;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_command;
    logic [6:0] o_cell_row;
    logic [7:0] o_cell_column;
    logic [7:0] o_glyph_code;
    logic       o_last_of_run;

    text_console_cursor_control #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_char_code(i_char_code),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_command(o_command),
        .o_cell_row(o_cell_row),
        .o_cell_column(o_cell_column),
        .o_glyph_code(o_glyph_code),
        .o_last_of_run(o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Character bytes still to send, and command words predicted but not yet seen
    int               char_feed[$];
    tccc_pkg::t_entry awaited_cmds[$];
    tccc_pkg::t_entry byte_run[$];

    // Predicted cursor
    tccc_pkg::t_row cur_row;
    tccc_pkg::t_col cur_col;

    int   mismatches = 0;
    int   acting_chars = 0;
    int   results_seen = 0;
    int   idle_cycles = 0;
    logic byte_taken = 1'b0;

    // ------------------------------------------------------------------
    // Cursor predictor
    // ------------------------------------------------------------------

    function void note_cmd(logic [2:0] cmd, int row, int col, logic [7:0] glyph);
        tccc_pkg::t_entry e;
        e.command = cmd;
        e.row = tccc_pkg::t_row'(row);
        e.col = tccc_pkg::t_col'(col);
        e.glyph = glyph;
        e.last = 1'b0;
        byte_run.push_back(e);
    endfunction

    // Drop erase and draw commands for cells off the screen
    function void note_cell(logic [2:0] cmd, int row, int col);
        if (row < ROWS && col < COLS) begin
            note_cmd(cmd, row, col, 8'd0);
        end
    endfunction

    // Erase the old cursor cell, relocate, draw the new one. A cursor sitting in the
    // wrap column always lands on column 0.
    function void set_cursor(int row, int col);
        note_cell(tccc_pkg::CmdErase, cur_row, cur_col);
        if (cur_col >= COLS) begin
            col = 0;
        end
        cur_row = tccc_pkg::t_row'(row);
        cur_col = tccc_pkg::t_col'(col);
        note_cell(tccc_pkg::CmdCursor, cur_row, cur_col);
    endfunction

    // Scroll once the cursor has dropped below the last row; land on the last row
    function void scroll_if_off();
        if (cur_row >= ROWS) begin
            note_cmd(tccc_pkg::CmdScroll, 0, 0, 8'd0);
            set_cursor(ROWS - 1, 0);
        end
    endfunction

    function void step_cursor(int row, int col);
        set_cursor(row, col);
        scroll_if_off();
    endfunction

    // Work out the command run of one accepted byte and queue it
    function void forecast_cmds(logic [7:0] ch);
        int r;
        int k;
        byte_run.delete();
        // Resolve a pending wrap first, whatever the byte is
        if (cur_col >= COLS) begin
            step_cursor(cur_row + 1, 0);
        end else begin
            scroll_if_off();
        end
        if (ch >= tccc_pkg::ChPrintFirst && ch <= tccc_pkg::ChPrintLast) begin
            r = cur_row;
            k = cur_col;
            step_cursor(cur_row, cur_col + 1);
            // Glyph follows the cursor commands
            if (r < ROWS && k < COLS) begin
                note_cmd(tccc_pkg::CmdGlyph, r, k, ch);
            end
        end else if (ch == tccc_pkg::ChBackspace) begin
            if (cur_col > 0) begin
                step_cursor(cur_row, cur_col - 1);
            end
        end else if (ch == tccc_pkg::ChTab) begin
            // Near the right edge a tab turns into a newline
            if (cur_col < COLS - tccc_pkg::TabStop) begin
                step_cursor(cur_row,
                            cur_col + (tccc_pkg::TabStop - (cur_col % tccc_pkg::TabStop)));
            end else begin
                step_cursor(cur_row + 1, 0);
            end
        end else if (ch == tccc_pkg::ChNewline) begin
            step_cursor(cur_row + 1, 0);
        end else if (ch == tccc_pkg::ChFormFeed) begin
            note_cmd(tccc_pkg::CmdClear, 0, 0, 8'd0);
            step_cursor(1, 0);
        end else if (ch == tccc_pkg::ChReturn) begin
            step_cursor(cur_row, 0);
        end
        if (byte_run.size() > 0) begin
            byte_run[byte_run.size() - 1].last = 1'b1;
        end
        foreach (byte_run[i]) begin
            awaited_cmds.push_back(byte_run[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Sample both channels at the rising edge. Check the outgoing word before predicting
    // the incoming byte: a word leaving now always belongs to an earlier byte.
    always @(posedge i_clk) begin
        tccc_pkg::t_entry want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (awaited_cmds.size() == 0) begin
                    $error("command word %0d at row %0d column %0d with nothing expected",
                           o_command, o_cell_row, o_cell_column);
                    mismatches++;
                end else begin
                    want = awaited_cmds.pop_front();
                    check_field("command", want.command, o_command);
                    check_field("cell_row", want.row, o_cell_row);
                    check_field("cell_column", want.col, o_cell_column);
                    check_field("glyph_code", want.glyph, o_glyph_code);
                    check_field("last_of_run", want.last, o_last_of_run);
                end
            end
            if (i_valid && !o_stall) begin
                forecast_cmds(i_char_code);
            end
            // Watchdog: count cycles in which neither side moves a word
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        byte_taken <= i_valid && !o_stall;
    end

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------

    int burst_left = 1;
    int gap_left = 0;

    always @(negedge i_clk) begin
        int next_char;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || byte_taken) begin
            if (char_feed.size() > 0 && char_feed[0] == DrainMark) begin
                // Pause until every predicted command has been received
                i_valid <= 1'b0;
                if (awaited_cmds.size() == 0) begin
                    void'(char_feed.pop_front());
                end
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (char_feed.size() > 0) begin
                next_char = char_feed.pop_front();
                i_valid <= 1'b1;
                i_char_code <= next_char[7:0];
                if (burst_left > 1) begin
                    burst_left--;
                end else if ($urandom_range(0, 4) == 0) begin
                    // Long stretch with no idling at all
                    burst_left = $urandom_range(30, 60);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 25)
                                                            : $urandom_range(0, 4);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches every so often, plus one long hold
    // ------------------------------------------------------------------

    t_stall_pattern stall_pattern = StallNone;
    int pattern_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && results_seen >= HoldAt) begin
            // Hold off long enough for the block to fill and stall its input
            hold_done = 1'b1;
            hold_left = HoldLen - 1;
            i_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                stall_pattern = t_stall_pattern'($urandom_range(0, 3));
                pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (stall_pattern)
                StallNone:      i_stall <= 1'b0;
                StallLight:     i_stall <= ($urandom_range(0, 3) == 0);
                StallHeavy:     i_stall <= ($urandom_range(0, 3) != 0);
                StallAlternate: i_stall <= ~i_stall;
                default:        i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function void add_char(int c);
        char_feed.push_back(c);
        if ((c >= tccc_pkg::ChPrintFirst && c <= tccc_pkg::ChPrintLast) ||
            c == tccc_pkg::ChBackspace || c == tccc_pkg::ChTab ||
            c == tccc_pkg::ChNewline || c == tccc_pkg::ChFormFeed ||
            c == tccc_pkg::ChReturn) begin
            acting_chars++;
        end
    endfunction

    function int random_print();
        return $urandom_range(tccc_pkg::ChPrintFirst, tccc_pkg::ChPrintLast);
    endfunction

    initial begin
        int pick;
        int count;
        int roll;
        bit drained;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_char_code = 8'd0;
        cur_row = 1;
        cur_col = 0;

        // Directed: clear, printable extremes, backspace down to and past column 0,
        // tab, return, newline, and ignored codes low and high
        add_char(tccc_pkg::ChFormFeed);
        add_char(tccc_pkg::ChPrintFirst);
        add_char(tccc_pkg::ChPrintLast);
        add_char(tccc_pkg::ChBackspace);
        add_char(tccc_pkg::ChBackspace);
        add_char(tccc_pkg::ChBackspace);
        add_char(tccc_pkg::ChTab);
        add_char(8'h41);
        add_char(tccc_pkg::ChTab);
        add_char(tccc_pkg::ChBackspace);
        add_char(tccc_pkg::ChReturn);
        add_char(tccc_pkg::ChNewline);
        add_char(8'd0);
        add_char(8'd7);
        add_char(8'd11);
        add_char(8'd31);
        add_char(8'd127);
        add_char(8'd128);
        add_char(8'd255);
        add_char(8'h7a);
        add_char(tccc_pkg::ChFormFeed);

        // Random: mostly well-formed text, edge runs and newline bursts, some noise
        drained = 1'b0;
        count = acting_chars;
        while (acting_chars < count + RandomChars) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // Text line with edits, closed by a newline
                repeat ($urandom_range(1, 20)) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7) add_char(random_print());
                    else if (roll == 7) add_char(tccc_pkg::ChBackspace);
                    else if (roll == 8) add_char(tccc_pkg::ChTab);
                    else add_char(tccc_pkg::ChReturn);
                end
                add_char(tccc_pkg::ChNewline);
            end else if (pick < 48) begin
                // Tab out to the right edge, type into the wrap, then one random byte
                add_char(tccc_pkg::ChReturn);
                repeat ((COLS - tccc_pkg::TabStop) / tccc_pkg::TabStop)
                    add_char(tccc_pkg::ChTab);
                repeat ($urandom_range(0, 9)) add_char(random_print());
                roll = $urandom_range(0, 5);
                if (roll == 0) add_char(tccc_pkg::ChTab);
                else if (roll == 1) add_char(tccc_pkg::ChBackspace);
                else if (roll == 2) add_char(tccc_pkg::ChReturn);
                else if (roll == 3) add_char(tccc_pkg::ChNewline);
                else if (roll == 4) add_char(tccc_pkg::ChFormFeed);
                else add_char($urandom_range(0, 255));
            end else if (pick < 75) begin
                // Newline burst: walk the cursor down into scrolling
                repeat ($urandom_range(5, 25)) add_char(tccc_pkg::ChNewline);
            end else if (pick < 77) begin
                add_char(tccc_pkg::ChFormFeed);
            end else begin
                repeat ($urandom_range(1, 4)) add_char($urandom_range(0, 255));
            end
            if (!drained && acting_chars > count + RandomChars / 2) begin
                char_feed.push_back(DrainMark);
                drained = 1'b1;
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Run until everything is sent and every predicted word is back, or the block hangs
        while ((char_feed.size() > 0 || i_valid || awaited_cmds.size() > 0) &&
               idle_cycles < IdleLimit) begin
            @(posedge i_clk);
        end

        if (idle_cycles >= IdleLimit) begin
            $display("Mismatches found");
        end else begin
            // Leave room for any stray word after the last expected one
            repeat (EndWait) @(posedge i_clk);
            if (awaited_cmds.size() > 0) begin
                $error("%0d expected command words never arrived", awaited_cmds.size());
                mismatches++;
            end
            if (mismatches == 0) begin
                $display("No mismatches found");
            end else begin
                $display("Mismatches found");
            end
        end
        $finish;
    end

endmodule
